// File: design/cbs_pkg.sv
package cbs_pkg;

  // widths fixed by the stream format
  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;

  // register reset values
  localparam logic [CFG_W-1:0] RESET_DIM = 11'd1024;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_index_t;

  // filter selection
  typedef enum logic {
    MODE_BLUR  = 1'b0,
    MODE_SOBEL = 1'b1
  } mode_t;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 window, [row][col], row 0 is the oldest line, col 0 the oldest column
  typedef pix_t [2:0][2:0] win_t;

  // position of an accepted pixel plus its border flags
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               row_ge1;
    logic               row_ge2;
    logic               col_ge1;
    logic               col_ge2;
    logic               row_last;
    logic               col_last;
  } pos_t;

  // one window handed to the result stage, with the results it completes
  typedef struct packed {
    win_t               win;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [3:0]         emits;
  } item_t;

endpackage

// File: design/cbs_line_buf.sv
module cbs_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output cbs_pkg::pix_t        rd_older,
  output cbs_pkg::pix_t        rd_newer,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  cbs_pkg::pix_t        wr_older,
  input  cbs_pkg::pix_t        wr_newer,
  output logic                 clearing
);

  cbs_pkg::pix_t older_mem [DEPTH];
  cbs_pkg::pix_t newer_mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // zero sweep after reset, one column per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // two line stores, one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (!rst && clearing) begin
      older_mem[clr_addr] <= '0;
      newer_mem[clr_addr] <= '0;
    end else if (!rst && wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
    if (rd_en) begin
      rd_older <= older_mem[rd_addr];
      rd_newer <= newer_mem[rd_addr];
    end
  end

endmodule

// File: design/cbs_window.sv
module cbs_window #(
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  cbs_pkg::pix_t   pixel_in,
  input  cbs_pkg::pos_t   pos_in,
  input  logic [AW-1:0]   addr_in,
  input  cbs_pkg::pix_t   rd_older,
  input  cbs_pkg::pix_t   rd_newer,
  input  logic            s2_ready,
  output logic            s1_busy,
  output logic            s1_adv,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output cbs_pkg::pix_t   wr_older,
  output cbs_pkg::pix_t   wr_newer,
  output cbs_pkg::item_t  item
);

  cbs_pkg::pix_t   s1_pixel;
  cbs_pkg::pos_t   s1_pos;
  logic [AW-1:0]   s1_addr;
  logic            s1_fwd;
  cbs_pkg::pix_t   fwd_older;
  cbs_pkg::pix_t   fwd_newer;
  cbs_pkg::pix_t   older_eff;
  cbs_pkg::pix_t   newer_eff;
  cbs_pkg::pix_t [2:0][1:0] wreg;
  cbs_pkg::pix_t [2:0] cur;
  logic [2:0]      row_ok;
  logic [2:0]      col_ok;

  assign s1_adv = s1_busy && s2_ready;

  // occupancy of the window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_busy <= 1'b0;
    end else if (accept) begin
      s1_busy <= 1'b1;
    end else if (s1_adv) begin
      s1_busy <= 1'b0;
    end
  end

  // capture the transaction; forward the line store write that lands on the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixel_in;
      s1_pos    <= pos_in;
      s1_addr   <= addr_in;
      s1_fwd    <= s1_adv && (s1_addr == addr_in);
      fwd_older <= newer_eff;
      fwd_newer <= s1_pixel;
    end
  end

  assign older_eff = s1_fwd ? fwd_older : rd_older;
  assign newer_eff = s1_fwd ? fwd_newer : rd_newer;
  assign cur       = {s1_pixel, newer_eff, older_eff};

  // line stores shift down by one row as the pixel leaves
  assign wr_en    = s1_adv;
  assign wr_addr  = s1_addr;
  assign wr_older = newer_eff;
  assign wr_newer = s1_pixel;

  // column history of the three rows
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        wreg[k][0] <= wreg[k][1];
        wreg[k][1] <= cur[k];
      end
    end
  end

  // zero the taps that fall above or left of the image
  assign row_ok = {1'b1, s1_pos.row_ge1, s1_pos.row_ge2};
  assign col_ok = {1'b1, s1_pos.col_ge1, s1_pos.col_ge2};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      item.win[k][0] = (row_ok[k] && col_ok[0]) ? wreg[k][0] : '0;
      item.win[k][1] = (row_ok[k] && col_ok[1]) ? wreg[k][1] : '0;
      item.win[k][2] = (row_ok[k] && col_ok[2]) ? cur[k]     : '0;
    end
    item.row      = s1_pos.row;
    item.col      = s1_pos.col;
    item.emits[0] = s1_pos.row_ge1  && s1_pos.col_ge1;
    item.emits[1] = s1_pos.row_ge1  && s1_pos.col_last;
    item.emits[2] = s1_pos.row_last && s1_pos.col_ge1;
    item.emits[3] = s1_pos.row_last && s1_pos.col_last;
  end

endmodule

// File: design/cbs_emit.sv
module cbs_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  cbs_pkg::mode_t                mode,
  input  logic                          load_valid,
  input  cbs_pkg::item_t                item_in,
  output logic                          s2_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cbs_pkg::PIX_W-1:0]     out_pixel,
  output logic [cbs_pkg::COORD_W-1:0]   out_row,
  output logic [cbs_pkg::COORD_W-1:0]   out_col,
  output logic                          frame_last
);

  logic [3:0]                 pend;
  logic [3:0]                 pend_next;
  cbs_pkg::win_t              win;
  logic [cbs_pkg::COORD_W-1:0] row;
  logic [cbs_pkg::COORD_W-1:0] col;
  logic [1:0]                 sel;
  logic                       fire;
  logic                       load;
  logic                       shift_x;
  logic                       shift_y;
  cbs_pkg::win_t              sw;
  cbs_pkg::pix_t              filt;

  // s rounded half to even after dividing by 8, 9-bit two's complement
  function automatic logic [8:0] rnd8(input logic [11:0] s);
    logic [8:0] q;
    logic       up;
    q  = s[11:3];
    up = (s[2:0] > 3'd4) || ((s[2:0] == 3'd4) && q[0]);
    return q + 9'(up);
  endfunction

  function automatic cbs_pkg::pix_t apply_filter(input cbs_pkg::mode_t m,
                                                 input cbs_pkg::win_t w);
    logic [11:0] blur;
    logic [11:0] left;
    logic [11:0] right;
    logic [11:0] top;
    logic [11:0] bottom;
    logic [8:0]  qx;
    logic [8:0]  qy;
    logic [8:0]  qb;
    logic [9:0]  v;
    logic        up;
    cbs_pkg::pix_t res;
    left   = 12'(w[0][0]) + {3'b0, w[1][0], 1'b0} + 12'(w[2][0]);
    right  = 12'(w[0][2]) + {3'b0, w[1][2], 1'b0} + 12'(w[2][2]);
    top    = 12'(w[0][0]) + {3'b0, w[0][1], 1'b0} + 12'(w[0][2]);
    bottom = 12'(w[2][0]) + {3'b0, w[2][1], 1'b0} + 12'(w[2][2]);
    blur   = top + bottom + {3'b0, w[1][0], 1'b0} + {3'b0, w[1][2], 1'b0}
           + {2'b0, w[1][1], 2'b0};
    up     = (blur[3:0] > 4'd8) || ((blur[3:0] == 4'd8) && blur[4]);
    qb     = {1'b0, blur[11:4]} + 9'(up);
    qx     = rnd8(left - right);
    qy     = rnd8(top - bottom);
    v      = {qx[8], qx} + {qy[8], qy};
    case (m)
      cbs_pkg::MODE_BLUR: begin
        res = qb[7:0];
      end
      cbs_pkg::MODE_SOBEL: begin
        if (v[9]) begin
          res = '0;
        end else if (v[8]) begin
          res = '1;
        end else begin
          res = v[7:0];
        end
      end
      default: begin
        res = qb[7:0];
      end
    endcase
    return res;
  endfunction

  // lowest pending result goes first
  always_comb begin
    if (pend[0]) begin
      sel = 2'd0;
    end else if (pend[1]) begin
      sel = 2'd1;
    end else if (pend[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign fire     = (pend != '0) && (!out_valid || !out_stall);
  assign s2_ready = (pend == '0) || (fire && $onehot(pend));
  assign load     = load_valid && s2_ready;
  assign shift_x  = sel[0];
  assign shift_y  = sel[1];

  always_comb begin
    pend_next = pend;
    if (fire) begin
      pend_next[sel] = 1'b0;
    end
    if (load) begin
      pend_next = item_in.emits;
    end
  end

  // slide the window so the selected output pixel sits in the middle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i + int'(shift_y) < 3) && (j + int'(shift_x) < 3)) begin
          sw[i][j] = win[i + int'(shift_y)][j + int'(shift_x)];
        end else begin
          sw[i][j] = '0;
        end
      end
    end
  end

  assign filt = apply_filter(mode, sw);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win <= item_in.win;
      row <= item_in.row;
      col <= item_in.col;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pixel  <= filt;
      out_row    <= shift_y ? row : row - 1'b1;
      out_col    <= shift_x ? col : col - 1'b1;
      frame_last <= shift_x && shift_y;
    end
  end

  a_pend_reaches_output: assert property (@(posedge clk) disable iff (rst)
    ((pend != '0) && !out_valid) |=> out_valid)
    else $error("pending result did not reach the output register");

  a_pend_counts_down: assert property (@(posedge clk) disable iff (rst)
    (fire && !load) |=> ($countones(pend) == $countones($past(pend)) - 1))
    else $error("pending results not retired one per transaction");

endmodule

// File: design/conv3x3_blur_sobel_stream.sv
// Streaming 3x3 filter over 8-bit raster pixels with zero padding at the image
// border: mode 0 is a 1-2-1 Gaussian blur (/16), mode 1 adds the rounded x and y
// Sobel responses (/8 each) and clamps to 0..255; all rounding is half to even.
// One pixel is taken per cycle while in_stall is low. A result leaves once its
// window is complete, tagged with row, column and a frame last flag; pixels on
// the last column or last row complete up to four windows, and the single
// result register drains them one per cycle while out_stall allows, so such a
// pixel holds the input while its extra results drain. Results at the
// bottom and right edge therefore come out of raster order. After reset the two
// line stores are zeroed column by column, during which no pixel is taken (but
// configuration writes are). Change configuration only while the stream is idle.
module conv3x3_blur_sobel_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cbs_pkg::IDX_W-1:0]     cfg_index,
  input  logic [cbs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cbs_pkg::PIX_W-1:0]     pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cbs_pkg::PIX_W-1:0]     out_pixel,
  output logic [cbs_pkg::COORD_W-1:0]   out_row,
  output logic [cbs_pkg::COORD_W-1:0]   out_col,
  output logic                          frame_last
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW    = (CW > RW) ? CW : RW;
  localparam int DIM_W = (PW + 1 > cbs_pkg::CFG_W) ? PW + 1 : cbs_pkg::CFG_W;

  cbs_pkg::mode_t             mode;
  logic [cbs_pkg::CFG_W-1:0]  cfg_width;
  logic [cbs_pkg::CFG_W-1:0]  cfg_height;
  logic [CW-1:0]              in_col;
  logic [RW-1:0]              in_row;
  logic [DIM_W-1:0]           w_raw;
  logic [DIM_W-1:0]           h_raw;
  logic [DIM_W-1:0]           w_eff;
  logic [DIM_W-1:0]           h_eff;
  logic [DIM_W-1:0]           col_ext;
  logic [DIM_W-1:0]           row_ext;
  logic [DIM_W-1:0]           col_cur;
  logic [DIM_W-1:0]           row_tmp;
  logic [DIM_W-1:0]           row_cur;
  logic [DIM_W-1:0]           col_inc;
  logic [DIM_W-1:0]           row_inc;
  logic [DIM_W-1:0]           col_next;
  logic [DIM_W-1:0]           row_next;
  logic                       accept;
  logic                       clearing;
  logic                       s1_busy;
  logic                       s1_adv;
  logic                       s2_ready;
  cbs_pkg::pos_t              pos;
  cbs_pkg::pix_t              rd_older;
  cbs_pkg::pix_t              rd_newer;
  logic                       wr_en;
  logic [CW-1:0]              wr_addr;
  cbs_pkg::pix_t              wr_older;
  cbs_pkg::pix_t              wr_newer;
  cbs_pkg::item_t             item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= cbs_pkg::MODE_BLUR;
      cfg_width  <= cbs_pkg::RESET_DIM;
      cfg_height <= cbs_pkg::RESET_DIM;
    end else if (cfg_write) begin
      case (cbs_pkg::reg_index_t'(cfg_index))
        cbs_pkg::REG_MODE:   mode       <= cbs_pkg::mode_t'(cfg_data[0]);
        cbs_pkg::REG_WIDTH:  cfg_width  <= cfg_data;
        cbs_pkg::REG_HEIGHT: cfg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // image size limited to 1..max
  assign w_raw = DIM_W'(cfg_width);
  assign h_raw = DIM_W'(cfg_height);
  assign w_eff = (w_raw == '0) ? DIM_W'(1) :
                 (w_raw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_raw;
  assign h_eff = (h_raw == '0) ? DIM_W'(1) :
                 (h_raw > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_raw;

  // position of this pixel, rewrapped in case the size shrank
  assign col_ext = DIM_W'(in_col);
  assign row_ext = DIM_W'(in_row);

  always_comb begin
    if (col_ext >= w_eff) begin
      col_cur = '0;
      row_tmp = row_ext + 1'b1;
    end else begin
      col_cur = col_ext;
      row_tmp = row_ext;
    end
    row_cur = (row_tmp >= h_eff) ? '0 : row_tmp;
    col_inc = col_cur + 1'b1;
    row_inc = row_cur + 1'b1;
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= h_eff) ? '0 : row_inc;
    end else begin
      col_next = col_inc;
      row_next = row_cur;
    end
  end

  always_comb begin
    pos.row      = cbs_pkg::COORD_W'(row_cur);
    pos.col      = cbs_pkg::COORD_W'(col_cur);
    pos.row_ge1  = (row_cur != '0);
    pos.row_ge2  = (row_cur > DIM_W'(1));
    pos.col_ge1  = (col_cur != '0);
    pos.col_ge2  = (col_cur > DIM_W'(1));
    pos.row_last = (row_cur == h_eff - 1'b1);
    pos.col_last = (col_cur == w_eff - 1'b1);
  end

  // input handshake
  assign in_stall = clearing || (s1_busy && !s2_ready);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
    end else if (accept) begin
      in_col <= CW'(col_next);
      in_row <= RW'(row_next);
    end
  end

  cbs_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (CW'(col_cur)),
    .rd_older (rd_older),
    .rd_newer (rd_newer),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_older (wr_older),
    .wr_newer (wr_newer),
    .clearing (clearing)
  );

  cbs_window #(
    .AW (CW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pixel_in (pixel),
    .pos_in   (pos),
    .addr_in  (CW'(col_cur)),
    .rd_older (rd_older),
    .rd_newer (rd_newer),
    .s2_ready (s2_ready),
    .s1_busy  (s1_busy),
    .s1_adv   (s1_adv),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_older (wr_older),
    .wr_newer (wr_newer),
    .item     (item)
  );

  cbs_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .load_valid (s1_busy),
    .item_in    (item),
    .s2_ready   (s2_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pixel  (out_pixel),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (in_stall && !s1_busy))
    else $error("pixel path active during line store clear");

  a_accept_fills_window: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_busy)
    else $error("accepted transaction missing from window stage");

  a_window_moves_on_handoff: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !accept) |=> !s1_busy)
    else $error("window stage kept a transaction it handed on");

endmodule
